// ----- hdl/linear_interpolating_upsampler_unit_macros.svh -----
// Assertion macros shared by the upsampler RTL.
`ifndef LINEAR_INTERPOLATING_UPSAMPLER_UNIT_MACROS_SVH
`define LINEAR_INTERPOLATING_UPSAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define LIU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define LIU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/liu_pkg.sv -----
// Shared types and constants of the linear interpolating upsampler.
`default_nettype none
package liu_pkg;

	localparam int SAMPLE_W          = 32;
	localparam int DIFF_W            = SAMPLE_W + 1;
	localparam int CNT_W             = 7;
	localparam int FIELD_LANES       = 4;
	localparam int LANES_DEFAULT     = 4;
	localparam int MAX_COUNT_DEFAULT = 64;
	localparam int DIV_STEPS         = DIFF_W;
	localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

	localparam logic [CNT_W-1:0] CFG_RESET = CNT_W'(10);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_0;
		logic signed [SAMPLE_W-1:0] sample_1;
		logic signed [SAMPLE_W-1:0] sample_2;
		logic signed [SAMPLE_W-1:0] sample_3;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value_0;
		logic signed [SAMPLE_W-1:0] value_1;
		logic signed [SAMPLE_W-1:0] value_2;
		logic signed [SAMPLE_W-1:0] value_3;
		logic                       last_of_run;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic first;
		logic div_step;
		logic div_fix;
		logic run_step;
	} lane_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/linear_interpolating_upsampler_unit.sv -----
// Linear interpolating upsampler top level: lanes, sequencer and merged output register.
// The first vector after reset skips the divider and gives a single result.
// Later vectors pass the per-lane bit-serial divider and a sign fix-up state, then give
// interval_count results at one per cycle unless stalled, and take no input until done.
// Reset clears the sequencer, the output valid flag, the stored vector and the count (10).
`default_nettype none
`include "linear_interpolating_upsampler_unit_macros.svh"
module linear_interpolating_upsampler_unit #(
	parameter int LANES     = liu_pkg::LANES_DEFAULT,
	parameter int MAX_COUNT = liu_pkg::MAX_COUNT_DEFAULT
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [liu_pkg::CNT_W-1:0]        cfg_wdata,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire liu_pkg::in_item_t           in_data,
	output logic                             out_valid,
	input  wire                              out_stall,
	output liu_pkg::out_item_t               out_data
);

	localparam int KW = $clog2(MAX_COUNT + 1);

	// One-hot sequencer: wait for a transaction, divide, fix the signs, then step.
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_FIX  = 4'b0100,
		ST_RUN  = 4'b1000
	} state_t;

	state_t                                state_q;
	state_t                                state_d;
	logic [liu_pkg::CNT_W-1:0]             cfg_q;
	logic [liu_pkg::CNT_W-1:0]             c_q;
	logic [liu_pkg::CNT_W-1:0]             eff_count;
	logic [KW-1:0]                         k_q;
	logic [liu_pkg::DIV_CNT_W-1:0]         div_cnt_q;
	logic                                  have_prev_q;
	logic                                  out_valid_q;
	liu_pkg::out_item_t                    out_q;
	liu_pkg::out_item_t                    merged;
	liu_pkg::lane_ctrl_t                   ctrl;

	logic                                  in_fire;
	logic                                  out_free;
	logic                                  run_fire;
	logic                                  run_last;
	logic                                  div_done;

	logic signed [liu_pkg::SAMPLE_W-1:0]   sample_arr [liu_pkg::FIELD_LANES];
	logic signed [liu_pkg::SAMPLE_W-1:0]   lane_val   [liu_pkg::FIELD_LANES];

	// Handshakes. A new transaction is taken only while the sequencer is idle; the output
	// register decouples the last result of one run from the acceptance of the next item.
	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign run_fire  = (state_q == ST_RUN) && out_free;
	assign run_last  = run_fire && (liu_pkg::CNT_W'(k_q) == c_q);
	assign div_done  = (div_cnt_q == liu_pkg::DIV_CNT_W'(liu_pkg::DIV_STEPS - 1));
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A count of zero behaves as one, and counts above the build limit are clamped.
	always_comb begin
		priority if (cfg_q == '0) begin
			eff_count = liu_pkg::CNT_W'(1);
		end else if (cfg_q > liu_pkg::CNT_W'(MAX_COUNT)) begin
			eff_count = liu_pkg::CNT_W'(MAX_COUNT);
		end else begin
			eff_count = cfg_q;
		end
	end

	// Lane control. The first vector skips the divider: its lanes load the sample with a
	// zero step, so a single step with a count of one reproduces the input.
	always_comb begin
		ctrl.load     = in_fire;
		ctrl.first    = !have_prev_q;
		ctrl.div_step = (state_q == ST_DIV);
		ctrl.div_fix  = (state_q == ST_FIX);
		ctrl.run_step = run_fire;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = have_prev_q ? ST_DIV : ST_RUN;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (run_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= liu_pkg::CFG_RESET;
			have_prev_q <= 1'b0;
			out_valid_q <= 1'b0;
			c_q         <= liu_pkg::CNT_W'(1);
			k_q         <= KW'(1);
			div_cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (in_fire) begin
				have_prev_q <= 1'b1;
				c_q         <= have_prev_q ? eff_count : liu_pkg::CNT_W'(1);
				k_q         <= KW'(1);
				div_cnt_q   <= '0;
			end else begin
				if (state_q == ST_DIV) begin
					div_cnt_q <= div_cnt_q + liu_pkg::DIV_CNT_W'(1);
				end
				if (run_fire) begin
					k_q <= k_q + KW'(1);
				end
			end
			if (run_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Lanes: one copy of the divider and accumulator per configured lane. Lanes beyond the
	// configured number read as zero in every result.
	assign sample_arr[0] = in_data.sample_0;
	assign sample_arr[1] = in_data.sample_1;
	assign sample_arr[2] = in_data.sample_2;
	assign sample_arr[3] = in_data.sample_3;

	for (genvar g = 0; g < liu_pkg::FIELD_LANES; g++) begin : g_lane
		if (g < LANES) begin : g_used
			liu_lane u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.divisor (c_q),
				.sample  (sample_arr[g]),
				.value   (lane_val[g])
			);
		end else begin : g_unused
			assign lane_val[g] = '0;
		end
	end

	// Merging stage: the lane values and the end-of-run mark form one result transaction.
	always_comb begin
		merged.value_0     = lane_val[0];
		merged.value_1     = lane_val[1];
		merged.value_2     = lane_val[2];
		merged.value_3     = lane_val[3];
		merged.last_of_run = (liu_pkg::CNT_W'(k_q) == c_q);
	end

	always_ff @(posedge clk) begin
		if (run_fire) begin
			out_q <= merged;
		end
	end

	`LIU_ASSERT_NXT(a_run_ends_idle, clk, arst_n, run_last, state_q == ST_IDLE,
		"sequencer did not return to idle after the last result")
	`LIU_ASSERT_IMP(a_step_in_range, clk, arst_n, state_q == ST_RUN,
		(k_q != '0) && (liu_pkg::CNT_W'(k_q) <= c_q), "step index outside the run")
	`LIU_ASSERT_IMP(a_count_in_range, clk, arst_n, state_q != ST_IDLE,
		(c_q != '0) && (c_q <= liu_pkg::CNT_W'(MAX_COUNT)), "latched count out of range")
	`LIU_ASSERT_IMP(a_fix_after_div, clk, arst_n, state_q == ST_FIX,
		$past(state_q) == ST_DIV, "sign fix-up entered without a division")

endmodule
`default_nettype wire

// ----- hdl/liu_lane.sv -----
// One interpolation lane: step divider followed by a quotient and remainder accumulator.
`default_nettype none
module liu_lane (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire liu_pkg::lane_ctrl_t               ctrl,
	input  wire        [liu_pkg::CNT_W-1:0]        divisor,
	input  wire signed [liu_pkg::SAMPLE_W-1:0]     sample,
	output logic signed [liu_pkg::SAMPLE_W-1:0]    value
);

	logic signed [liu_pkg::SAMPLE_W-1:0] acc_q;
	logic                                neg_q;
	logic        [liu_pkg::DIFF_W-1:0]   mag_q;
	logic        [liu_pkg::CNT_W-1:0]    rem_q;
	logic signed [liu_pkg::DIFF_W-1:0]   dq_q;
	logic        [liu_pkg::CNT_W-1:0]    dr_q;
	logic        [liu_pkg::CNT_W-1:0]    r_q;

	logic signed [liu_pkg::DIFF_W-1:0]   diff;
	logic        [liu_pkg::DIFF_W-1:0]   mag;
	logic        [liu_pkg::CNT_W:0]      rem_sh;
	logic                                rem_ge;
	logic        [liu_pkg::CNT_W:0]      r_sum;
	logic                                wrap;
	logic        [liu_pkg::CNT_W:0]      r_next;
	logic signed [liu_pkg::DIFF_W-1:0]   acc_next;

	// The stored vector lives in the accumulator: after the last step it equals the input.
	assign diff   = {sample[liu_pkg::SAMPLE_W-1], sample} - {acc_q[liu_pkg::SAMPLE_W-1], acc_q};
	assign mag    = diff[liu_pkg::DIFF_W-1] ? -diff : diff;

	assign rem_sh = {rem_q, mag_q[liu_pkg::DIFF_W-1]};
	assign rem_ge = rem_sh >= {1'b0, divisor};

	assign r_sum    = {1'b0, r_q} + {1'b0, dr_q};
	assign wrap     = r_sum >= {1'b0, divisor};
	assign r_next   = wrap ? (r_sum - {1'b0, divisor}) : r_sum;
	assign acc_next = {acc_q[liu_pkg::SAMPLE_W-1], acc_q} + dq_q
		+ {{(liu_pkg::DIFF_W-1){1'b0}}, wrap};
	assign value    = acc_next[liu_pkg::SAMPLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.load && ctrl.first) begin
			acc_q <= sample;
		end else if (ctrl.run_step) begin
			acc_q <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			neg_q <= diff[liu_pkg::DIFF_W-1];
			mag_q <= mag;
			rem_q <= '0;
			r_q   <= '0;
			if (ctrl.first) begin
				dq_q <= '0;
				dr_q <= '0;
			end
		end else if (ctrl.div_step) begin
			// Restoring division, one quotient bit per cycle shifted in at the bottom.
			if (rem_ge) begin
				rem_q <= liu_pkg::CNT_W'(rem_sh - {1'b0, divisor});
				mag_q <= {mag_q[liu_pkg::DIFF_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[liu_pkg::CNT_W-1:0];
				mag_q <= {mag_q[liu_pkg::DIFF_W-2:0], 1'b0};
			end
		end else if (ctrl.div_fix) begin
			// Turn the magnitude quotient into a floored signed quotient and remainder.
			if (!neg_q) begin
				dq_q <= mag_q;
				dr_q <= rem_q;
			end else if (rem_q == '0) begin
				dq_q <= -mag_q;
				dr_q <= '0;
			end else begin
				dq_q <= ~mag_q;
				dr_q <= divisor - rem_q;
			end
		end else if (ctrl.run_step) begin
			r_q <= r_next[liu_pkg::CNT_W-1:0];
		end
	end

endmodule
`default_nettype wire
